>>> rtl/assert_macros.svh
// shared assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define OGRU_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen outside reset
`define OGRU_ASSERT_NEVER(name, clk, rst_n, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> rtl/ogru_pkg.sv
package ogru_pkg;

  // default geometry
  localparam int GRID_COLS_DEF  = 256;
  localparam int GRID_ROWS_DEF  = 256;
  localparam int CELL_BITS_DEF  = 16;
  localparam int COORD_BITS_DEF = 16;

  // fixed field widths
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int VAL_W      = 16;
  localparam int CNT_W      = 10;
  localparam int DIM_W      = 9;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HIT_INC  = 3'd0,
    REG_MISS_INC = 3'd1,
    REG_CELL_MAX = 3'd2,
    REG_CELL_MIN = 3'd3,
    REG_GRID_W   = 3'd4,
    REG_GRID_H   = 3'd5
  } cfg_reg_e;

  typedef enum logic {
    CMD_TRACE = 1'b0,
    CMD_READ  = 1'b1
  } cmd_e;

  // register reset values, Q7.8 where signed
  localparam logic signed [VAL_W-1:0] HIT_INC_RST  = 16'sd230;
  localparam logic signed [VAL_W-1:0] MISS_INC_RST = -16'sd179;
  localparam logic signed [VAL_W-1:0] CELL_MAX_RST = 16'sd1280;
  localparam logic signed [VAL_W-1:0] CELL_MIN_RST = -16'sd512;
  localparam logic [DIM_W-1:0]        GRID_DIM_RST = 9'd200;

  typedef struct packed {
    logic signed [VAL_W-1:0] hit_inc;
    logic signed [VAL_W-1:0] miss_inc;
    logic signed [VAL_W-1:0] cell_max;
    logic signed [VAL_W-1:0] cell_min;
    logic [DIM_W-1:0]        grid_w;
    logic [DIM_W-1:0]        grid_h;
  } cfg_t;

  // status from the walker back to the front and the queue
  typedef struct packed {
    logic clearing;
    logic take;
  } back_stat_t;

endpackage

>>> rtl/occupancy_grid_ray_update.sv
// Occupancy grid of signed log-odds cells (Q7.8) updated along Bresenham rays. After reset
// the block first clears the whole grid, one cell per cycle, with busy high throughout;
// configuration writes are taken during that time. A command is taken when start is high and
// busy is low; a two-beat queue sits between the command front end and the walker, so up to
// two commands can wait while a ray is being traced, and after the clear busy only rises when
// that queue is full. Each command gives exactly one result beat, shown for one cycle with
// done_o high; the receiver cannot stall it. The walker does a read-modify-write on a grid
// memory with registered read data, stepping through the states address, read and update
// for each visited cell; a read command passes through them once.
module occupancy_grid_ray_update import ogru_pkg::*; #(
  parameter int GRID_COLS  = GRID_COLS_DEF,
  parameter int GRID_ROWS  = GRID_ROWS_DEF,
  parameter int CELL_BITS  = CELL_BITS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // command beat
  input  logic                         start,
  output logic                         busy,
  input  logic                         cmd_i,
  input  logic signed [COORD_BITS-1:0] start_x_i,
  input  logic signed [COORD_BITS-1:0] start_y_i,
  input  logic signed [COORD_BITS-1:0] end_x_i,
  input  logic signed [COORD_BITS-1:0] end_y_i,
  input  logic                         endpoint_hit_i,
  // result beat
  output logic                         done_o,
  output logic signed [VAL_W-1:0]      cell_value_o,
  output logic [CNT_W-1:0]             cells_updated_o,
  output logic                         reached_end_o,
  output logic                         in_range_o,
  // register write channel
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [CFG_DATA_W-1:0]        cfg_data_i
);

  localparam int ErrW = COORD_BITS + 3;
  // queue beat: command, hit, two step signs, four coordinates, dx, dy, error term
  localparam int JobW = 4 + 4 * COORD_BITS + 3 * ErrW;

  cfg_t             cfg_q;
  back_stat_t       stat;
  logic             push;
  logic             q_full;
  logic             q_valid;
  logic [JobW-1:0]  job_in;
  logic [JobW-1:0]  job_out;

  // registers accept a write every cycle
  assign cfg_ready_o = 1'b1;

  // register file, indexes past the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hit_inc  <= HIT_INC_RST;
      cfg_q.miss_inc <= MISS_INC_RST;
      cfg_q.cell_max <= CELL_MAX_RST;
      cfg_q.cell_min <= CELL_MIN_RST;
      cfg_q.grid_w   <= GRID_DIM_RST;
      cfg_q.grid_h   <= GRID_DIM_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_HIT_INC:  cfg_q.hit_inc  <= signed'(cfg_data_i);
        REG_MISS_INC: cfg_q.miss_inc <= signed'(cfg_data_i);
        REG_CELL_MAX: cfg_q.cell_max <= signed'(cfg_data_i);
        REG_CELL_MIN: cfg_q.cell_min <= signed'(cfg_data_i);
        REG_GRID_W:   cfg_q.grid_w   <= cfg_data_i[DIM_W-1:0];
        REG_GRID_H:   cfg_q.grid_h   <= cfg_data_i[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // front end: takes the command and sets up the line deltas
  ogru_front #(
    .COORD_BITS (COORD_BITS),
    .JOB_W      (JobW)
  ) u_front (
    .start_i        (start),
    .cmd_i          (cmd_i),
    .start_x_i      (start_x_i),
    .start_y_i      (start_y_i),
    .end_x_i        (end_x_i),
    .end_y_i        (end_y_i),
    .endpoint_hit_i (endpoint_hit_i),
    .stat_i         (stat),
    .full_i         (q_full),
    .busy_o         (busy),
    .push_o         (push),
    .job_o          (job_in)
  );

  // two-entry command queue
  ogru_queue #(
    .W (JobW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .stat_i  (stat),
    .full_o  (q_full),
    .valid_o (q_valid),
    .data_o  (job_out)
  );

  // walker with the grid memory and the clearing pass
  ogru_back #(
    .GRID_COLS  (GRID_COLS),
    .GRID_ROWS  (GRID_ROWS),
    .CELL_BITS  (CELL_BITS),
    .COORD_BITS (COORD_BITS),
    .JOB_W      (JobW)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .q_valid_i       (q_valid),
    .job_i           (job_out),
    .stat_o          (stat),
    .done_o          (done_o),
    .cell_value_o    (cell_value_o),
    .cells_updated_o (cells_updated_o),
    .reached_end_o   (reached_end_o),
    .in_range_o      (in_range_o)
  );

endmodule

>>> rtl/ogru_front.sv
module ogru_front import ogru_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int JOB_W      = 4 + 4 * COORD_BITS_DEF + 3 * (COORD_BITS_DEF + 3)
) (
  input  logic                         start_i,
  input  logic                         cmd_i,
  input  logic signed [COORD_BITS-1:0] start_x_i,
  input  logic signed [COORD_BITS-1:0] start_y_i,
  input  logic signed [COORD_BITS-1:0] end_x_i,
  input  logic signed [COORD_BITS-1:0] end_y_i,
  input  logic                         endpoint_hit_i,
  input  back_stat_t                   stat_i,
  input  logic                         full_i,
  output logic                         busy_o,
  output logic                         push_o,
  output logic [JOB_W-1:0]             job_o
);

  localparam int ErrW = COORD_BITS + 3;

  // must match the layout in ogru_back
  typedef struct packed {
    cmd_e                        cmd;
    logic                        hit;
    logic                        sx_pos;
    logic                        sy_pos;
    logic signed [COORD_BITS-1:0] x0;
    logic signed [COORD_BITS-1:0] y0;
    logic signed [COORD_BITS-1:0] x1;
    logic signed [COORD_BITS-1:0] y1;
    logic signed [ErrW-1:0]      dx;
    logic signed [ErrW-1:0]      dy;
    logic signed [ErrW-1:0]      err;
  } job_t;

  logic signed [ErrW-1:0] diff_x;
  logic signed [ErrW-1:0] diff_y;
  job_t                   job;

  always_comb begin
    diff_x     = ErrW'(end_x_i) - ErrW'(start_x_i);
    diff_y     = ErrW'(end_y_i) - ErrW'(start_y_i);
    job.cmd    = cmd_e'(cmd_i);
    job.hit    = endpoint_hit_i;
    job.sx_pos = (start_x_i < end_x_i);
    job.sy_pos = (start_y_i < end_y_i);
    job.x0     = start_x_i;
    job.y0     = start_y_i;
    job.x1     = end_x_i;
    job.y1     = end_y_i;
    job.dx     = diff_x[ErrW-1] ? -diff_x : diff_x;
    job.dy     = diff_y[ErrW-1] ? -diff_y : diff_y;
    job.err    = job.dx - job.dy;
  end

  assign busy_o = stat_i.clearing | full_i;
  assign push_o = start_i & ~busy_o;
  assign job_o  = job;

endmodule

>>> rtl/ogru_queue.sv
`include "assert_macros.svh"

module ogru_queue import ogru_pkg::*; #(
  parameter int W = 4 + 4 * COORD_BITS_DEF + 3 * (COORD_BITS_DEF + 3)
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  input  back_stat_t   stat_i,
  output logic         full_o,
  output logic         valid_o,
  output logic [W-1:0] data_o
);

  localparam logic [1:0] QFull = 2'd2;

  logic [W-1:0] slot_q [2];
  logic         wr_q;
  logic         rd_q;
  logic [1:0]   cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (stat_i.take) begin
        rd_q <= ~rd_q;
      end
      if (push_i && !stat_i.take) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (!push_i && stat_i.take) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= data_i;
    end
  end

  assign full_o  = (cnt_q == QFull);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = slot_q[rd_q];

  `OGRU_ASSERT_NEVER(a_no_overflow, clk_i, rst_ni, push_i && cnt_q == QFull, "push into full queue")
  `OGRU_ASSERT_NEVER(a_no_underflow, clk_i, rst_ni, stat_i.take && cnt_q == 2'd0, "pop from empty queue")

endmodule

>>> rtl/ogru_back.sv
`include "assert_macros.svh"

module ogru_back import ogru_pkg::*; #(
  parameter int GRID_COLS  = GRID_COLS_DEF,
  parameter int GRID_ROWS  = GRID_ROWS_DEF,
  parameter int CELL_BITS  = CELL_BITS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int JOB_W      = 4 + 4 * COORD_BITS_DEF + 3 * (COORD_BITS_DEF + 3)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cfg_t                    cfg_i,
  input  logic                    q_valid_i,
  input  logic [JOB_W-1:0]        job_i,
  output back_stat_t              stat_o,
  output logic                    done_o,
  output logic signed [VAL_W-1:0] cell_value_o,
  output logic [CNT_W-1:0]        cells_updated_o,
  output logic                    reached_end_o,
  output logic                    in_range_o
);

  localparam int ErrW  = COORD_BITS + 3;
  localparam int CW    = COORD_BITS + 1;
  localparam int IW    = COORD_BITS + 2;
  localparam int Depth = GRID_COLS * GRID_ROWS;
  localparam int AW    = $clog2(Depth);
  localparam int XW    = $clog2(GRID_COLS);
  localparam int YW    = $clog2(GRID_ROWS);
  localparam int SW    = ((CELL_BITS > VAL_W) ? CELL_BITS : VAL_W) + 1;

  localparam logic [AW-1:0]        LastAddr = AW'(Depth - 1);
  localparam logic signed [SW-1:0] OutMax   = SW'(32'sd32767);
  localparam logic signed [SW-1:0] OutMin   = SW'(-32'sd32768);
  localparam logic signed [SW-1:0] CellHi   = SW'((64'sd1 <<< (CELL_BITS - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] CellLo   = SW'(-(64'sd1 <<< (CELL_BITS - 1)));

  // must match the layout in ogru_front
  typedef struct packed {
    cmd_e                        cmd;
    logic                        hit;
    logic                        sx_pos;
    logic                        sy_pos;
    logic signed [COORD_BITS-1:0] x0;
    logic signed [COORD_BITS-1:0] y0;
    logic signed [COORD_BITS-1:0] x1;
    logic signed [COORD_BITS-1:0] y1;
    logic signed [ErrW-1:0]      dx;
    logic signed [ErrW-1:0]      dy;
    logic signed [ErrW-1:0]      err;
  } job_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ADDR,
    S_READ,
    S_UPD
  } state_e;

  state_e                       state_q;
  logic [AW-1:0]                clr_q;
  cmd_e                         cmd_q;
  logic                         hit_q;
  logic                         sxp_q;
  logic                         syp_q;
  logic signed [COORD_BITS-1:0] x1_q;
  logic signed [COORD_BITS-1:0] y1_q;
  logic signed [ErrW-1:0]       dx_q;
  logic signed [ErrW-1:0]       dy_q;
  logic signed [ErrW-1:0]       err_q;
  logic signed [CW-1:0]         cx_q;
  logic signed [CW-1:0]         cy_q;
  logic                         first_q;
  logic                         in_q;
  logic                         end_q;
  logic [AW-1:0]                addr_q;
  logic [CNT_W-1:0]             cnt_q;
  logic                         done_q;
  logic signed [VAL_W-1:0]      val_q;
  logic [CNT_W-1:0]             cells_q;
  logic                         reached_q;
  logic                         inr_q;

  logic signed [CELL_BITS-1:0]  grid_mem [Depth];
  logic signed [CELL_BITS-1:0]  rd_q;

  job_t                  job;
  logic                  take;
  logic signed [IW-1:0]  cols_lim;
  logic signed [IW-1:0]  rows_lim;
  logic signed [IW-1:0]  cx_e;
  logic signed [IW-1:0]  cy_e;
  logic                  inside_now;
  logic                  is_end_now;
  logic [AW-1:0]         addr_now;
  logic signed [ErrW-1:0] e2;
  logic                  step_x;
  logic                  step_y;
  logic signed [ErrW-1:0] err_nx;
  logic signed [CW-1:0]  cx_nx;
  logic signed [CW-1:0]  cy_nx;
  logic signed [VAL_W-1:0] delta;
  logic signed [SW-1:0]  sum;
  logic signed [SW-1:0]  upd_v;
  logic signed [SW-1:0]  rd_ext;
  logic signed [VAL_W-1:0] rd_sat;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic signed [CELL_BITS-1:0] mem_wdata;

  assign job  = job_t'(job_i);
  assign take = (state_q == S_IDLE) && q_valid_i;

  // grid bounds in use, oversized settings fall back to the full grid
  always_comb begin
    cols_lim = (IW'(cfg_i.grid_w) > IW'(GRID_COLS)) ? IW'(GRID_COLS) : IW'(cfg_i.grid_w);
    rows_lim = (IW'(cfg_i.grid_h) > IW'(GRID_ROWS)) ? IW'(GRID_ROWS) : IW'(cfg_i.grid_h);
    cx_e     = IW'(cx_q);
    cy_e     = IW'(cy_q);
    inside_now = (cx_e >= 0) && (cx_e < cols_lim) && (cy_e >= 0) && (cy_e < rows_lim);
    is_end_now = (cx_q == CW'(x1_q)) && (cy_q == CW'(y1_q));
    addr_now   = AW'(cy_q[YW-1:0]) * AW'(GRID_COLS) + AW'(cx_q[XW-1:0]);
  end

  // one bresenham step
  always_comb begin
    e2     = err_q <<< 1;
    step_x = e2 > -dy_q;
    step_y = e2 < dx_q;
    err_nx = err_q - (step_x ? dy_q : '0) + (step_y ? dx_q : '0);
    cx_nx  = cx_q;
    cy_nx  = cy_q;
    if (step_x) begin
      cx_nx = sxp_q ? cx_q + CW'(1) : cx_q - CW'(1);
    end
    if (step_y) begin
      cy_nx = syp_q ? cy_q + CW'(1) : cy_q - CW'(1);
    end
  end

  // saturating log-odds update, cell_max first then cell_min
  always_comb begin
    delta = (end_q && hit_q) ? cfg_i.hit_inc : cfg_i.miss_inc;
    sum   = SW'(rd_q) + SW'(delta);
    upd_v = sum;
    if (upd_v > SW'(cfg_i.cell_max)) begin
      upd_v = SW'(cfg_i.cell_max);
    end
    if (upd_v < SW'(cfg_i.cell_min)) begin
      upd_v = SW'(cfg_i.cell_min);
    end
    if (upd_v > CellHi) begin
      upd_v = CellHi;
    end
    if (upd_v < CellLo) begin
      upd_v = CellLo;
    end
    rd_ext = SW'(rd_q);
    if (rd_ext > OutMax) begin
      rd_sat = VAL_W'(OutMax);
    end else if (rd_ext < OutMin) begin
      rd_sat = VAL_W'(OutMin);
    end else begin
      rd_sat = VAL_W'(rd_ext);
    end
  end

  always_comb begin
    mem_we    = (state_q == S_CLEAR) || (state_q == S_UPD && cmd_q == CMD_TRACE && in_q);
    mem_waddr = (state_q == S_CLEAR) ? clr_q : addr_q;
    mem_wdata = (state_q == S_CLEAR) ? '0 : CELL_BITS'(upd_v);
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      grid_mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= grid_mem[addr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_q     <= '0;
      cmd_q     <= CMD_TRACE;
      hit_q     <= 1'b0;
      sxp_q     <= 1'b0;
      syp_q     <= 1'b0;
      x1_q      <= '0;
      y1_q      <= '0;
      dx_q      <= '0;
      dy_q      <= '0;
      err_q     <= '0;
      cx_q      <= '0;
      cy_q      <= '0;
      first_q   <= 1'b0;
      in_q      <= 1'b0;
      end_q     <= 1'b0;
      addr_q    <= '0;
      cnt_q     <= '0;
      done_q    <= 1'b0;
      val_q     <= '0;
      cells_q   <= '0;
      reached_q <= 1'b0;
      inr_q     <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == LastAddr) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (take) begin
            cmd_q   <= job.cmd;
            hit_q   <= job.hit;
            sxp_q   <= job.sx_pos;
            syp_q   <= job.sy_pos;
            x1_q    <= job.x1;
            y1_q    <= job.y1;
            dx_q    <= job.dx;
            dy_q    <= job.dy;
            err_q   <= job.err;
            cx_q    <= CW'(job.x0);
            cy_q    <= CW'(job.y0);
            first_q <= 1'b1;
            cnt_q   <= '0;
            state_q <= S_ADDR;
          end
        end
        S_ADDR: begin
          in_q   <= inside_now;
          end_q  <= is_end_now;
          addr_q <= addr_now;
          // a step that leaves the grid ends the walk
          if (!first_q && !inside_now) begin
            done_q    <= 1'b1;
            val_q     <= '0;
            cells_q   <= cnt_q;
            reached_q <= 1'b0;
            inr_q     <= 1'b0;
            state_q   <= S_IDLE;
          end else begin
            state_q <= S_READ;
          end
        end
        S_READ: begin
          state_q <= S_UPD;
        end
        S_UPD: begin
          first_q <= 1'b0;
          if (cmd_q == CMD_READ) begin
            done_q    <= 1'b1;
            val_q     <= in_q ? rd_sat : '0;
            cells_q   <= '0;
            reached_q <= 1'b0;
            inr_q     <= in_q;
            state_q   <= S_IDLE;
          end else begin
            if (in_q) begin
              cnt_q <= cnt_q + CNT_W'(1);
            end
            if (end_q) begin
              done_q    <= 1'b1;
              val_q     <= '0;
              cells_q   <= cnt_q + CNT_W'(in_q);
              reached_q <= 1'b1;
              inr_q     <= 1'b0;
              state_q   <= S_IDLE;
            end else begin
              err_q   <= err_nx;
              cx_q    <= cx_nx;
              cy_q    <= cy_nx;
              state_q <= S_ADDR;
            end
          end
        end
        default: begin
          state_q <= S_CLEAR;
        end
      endcase
    end
  end

  assign stat_o          = '{clearing: (state_q == S_CLEAR), take: take};
  assign done_o          = done_q;
  assign cell_value_o    = val_q;
  assign cells_updated_o = cells_q;
  assign reached_end_o   = reached_q;
  assign in_range_o      = inr_q;

  `OGRU_ASSERT(a_done_single, clk_i, rst_ni, done_q |=> !done_q, "result strobe longer than one cycle")
  `OGRU_ASSERT(a_read_clean, clk_i, rst_ni, (done_q && inr_q) |-> (cells_q == '0 && !reached_q), "read result carries trace fields")
  `OGRU_ASSERT_NEVER(a_no_take_clear, clk_i, rst_ni, take && state_q == S_CLEAR, "command taken during clear")

endmodule
